// ----- sv/lowest_index_room_allocator_assert.svh -----
// assertion macros for the room allocator checker
// each macro expects a signal named clk in the calling scope, the first two also rst
`ifndef LOWEST_INDEX_ROOM_ALLOCATOR_ASSERT_SVH
`define LOWEST_INDEX_ROOM_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define LIRA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define LIRA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds through reset
`define LIRA_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lira_pkg.sv -----
// shared types and fixed widths for the lowest-index room allocator
// no dependencies
`default_nettype none

package lira_pkg;

  localparam int CFG_W      = 5;
  localparam int IN_W       = 32;
  localparam int COUNT_W    = 32;
  localparam int ROOM_W     = 4;
  localparam int OUT_TIME_W = 48;

  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BOOK,
    ST_RESULT
  } lira_state_t;

  // controls the scan accumulator for one returning read
  typedef struct packed {
    logic step;
    logic first;
  } lira_scan_ctl_t;

endpackage

`default_nettype wire

// ----- sv/lira_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module lira_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/lira_scan.sv -----
// scan accumulator: tracks lowest free room and earliest room over a read stream
// depends on lira_pkg
`default_nettype none

module lira_scan #(
  parameter int IDX_W     = 4,
  parameter int TIME_BITS = 48
) (
  input  logic                          clk,
  input  lira_pkg::lira_scan_ctl_t      ctl,
  input  logic [IDX_W-1:0]              rd_idx,
  input  logic [TIME_BITS-1:0]          rd_free,
  input  logic [lira_pkg::IN_W-1:0]     start_q,
  output logic                          found,
  output logic [IDX_W-1:0]              pick,
  output logic [IDX_W-1:0]              early,
  output logic [TIME_BITS-1:0]          early_val
);

  import lira_pkg::*;

  logic is_free;

  assign is_free = (rd_free <= TIME_BITS'(start_q));

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (ctl.first) begin
        found     <= is_free;
        pick      <= rd_idx;
        early     <= rd_idx;
        early_val <= rd_free;
      end else begin
        // first free room wins, later ones are ignored
        if (!found && is_free) begin
          found <= 1'b1;
          pick  <= rd_idx;
        end
        if (rd_free < early_val) begin
          early     <= rd_idx;
          early_val <= rd_free;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/lowest_index_room_allocator.sv -----
// Lowest-index room allocator: places each request (start_time, stop_time) in a room.
// Channels: cfg (valid/ready, num_rooms), in (valid/ready, start_time and stop_time),
// out (valid/ready, room, actual_start, actual_end, delayed, overflow, busiest_room).
// One result item per input item, in order.
// Room free times and booking counts live in two synchronous rams; a valid bit per
// room stands for the cleared state, so reset takes effect at once with no sweep.
// Each item reads the free time of every room in use, one read per cycle on the
// free-time ram port, then reads the booking count of the chosen room and writes
// both entries back.
// One item at a time; the next item is taken as soon as the last item's result sits
// in the output register.
// A stalled receiver holds the output register; a finished item waits in the
// allocator until that register frees, with in_ready low meanwhile.
// Reset clears all free times, counts, the busiest room and sets num_rooms to 16.
// in_ready and cfg_ready stay low during reset; cfg_ready is high otherwise.
// Write num_rooms only while no item is in flight.
// depends on lira_pkg, lira_ram, lira_scan
`default_nettype none

module lowest_index_room_allocator #(
  parameter int MAX_ROOMS = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lira_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lira_pkg::IN_W-1:0]         start_time,
  input  logic [lira_pkg::IN_W-1:0]         stop_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lira_pkg::ROOM_W-1:0]       room,
  output logic [lira_pkg::OUT_TIME_W-1:0]   actual_start,
  output logic [lira_pkg::OUT_TIME_W-1:0]   actual_end,
  output logic                              delayed,
  output logic                              overflow,
  output logic [lira_pkg::ROOM_W-1:0]       busiest_room
);

  import lira_pkg::*;

  localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int CNT_W = $clog2(MAX_ROOMS + 1);

  lira_state_t state, state_next;

  logic [CFG_W-1:0]     num_rooms;
  logic [CNT_W-1:0]     n_lim;
  logic [IN_W-1:0]      start_q;
  logic [IN_W-1:0]      end_q;
  logic [CNT_W-1:0]     addr_cnt;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     rd_addr_q;
  logic                 rd_pend;
  logic                 free_vld_q;
  logic                 book_vld_q;
  logic [MAX_ROOMS-1:0] room_vld;
  logic [IDX_W-1:0]     best_room;
  logic [COUNT_W-1:0]   best_count;

  logic free_rd_en;
  logic book_rd_en;
  logic fire;

  logic [TIME_BITS-1:0] free_rd;
  logic [TIME_BITS-1:0] free_rd_m;
  logic [COUNT_W-1:0]   book_rd;

  lira_scan_ctl_t       scan_ctl;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [IDX_W-1:0]     early;
  logic [TIME_BITS-1:0] early_val;

  logic [IDX_W-1:0]     sel;
  logic [TIME_BITS-1:0] a_start;
  logic [IN_W-1:0]      dur;
  logic [TIME_BITS:0]   a_sum;
  logic                 ovf;
  logic [TIME_BITS-1:0] a_end;
  logic [COUNT_W-1:0]   bk;
  logic [COUNT_W-1:0]   cnt_new;
  logic                 better;
  logic [IDX_W-1:0]     best_room_next;

  logic [IDX_W+ROOM_W-1:0]          sel_ext;
  logic [IDX_W+ROOM_W-1:0]          best_ext;
  logic [TIME_BITS+OUT_TIME_W-1:0]  a_start_ext;
  logic [TIME_BITS+OUT_TIME_W-1:0]  a_end_ext;

  assign cfg_ready = !rst;

  // zero rooms acts as one, too many as the maximum
  always_comb begin
    if (num_rooms == '0) begin
      n_lim = CNT_W'(1);
    end else if (32'(num_rooms) > 32'(MAX_ROOMS)) begin
      n_lim = CNT_W'(MAX_ROOMS);
    end else begin
      n_lim = CNT_W'(num_rooms);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    free_rd_en = 1'b0;
    book_rd_en = 1'b0;
    fire       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_cnt < n_lim) begin
          free_rd_en = 1'b1;
        end else begin
          // last read returns this cycle, scan result is final next cycle
          state_next = ST_BOOK;
        end
      end
      ST_BOOK: begin
        book_rd_en = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          fire       = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  assign rd_addr = addr_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rooms  <= CFG_RESET;
      rd_pend    <= 1'b0;
      room_vld   <= '0;
      best_room  <= '0;
      best_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_rooms <= cfg_data;
      end
      rd_pend <= free_rd_en;
      if (fire) begin
        room_vld[sel] <= 1'b1;
        best_room     <= best_room_next;
        if (better) begin
          best_count <= cnt_new;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      start_q  <= start_time;
      end_q    <= stop_time;
      addr_cnt <= '0;
    end else if (free_rd_en) begin
      addr_cnt <= addr_cnt + CNT_W'(1);
    end
    if (free_rd_en) begin
      rd_addr_q  <= rd_addr;
      free_vld_q <= room_vld[rd_addr];
    end
    if (book_rd_en) begin
      book_vld_q <= room_vld[sel];
    end
  end

  lira_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_ROOMS)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (fire),
    .wr_addr (sel),
    .wr_data (a_end),
    .rd_en   (free_rd_en),
    .rd_addr (rd_addr),
    .rd_data (free_rd)
  );

  lira_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_ROOMS)
  ) u_book_ram (
    .clk     (clk),
    .wr_en   (fire),
    .wr_addr (sel),
    .wr_data (cnt_new),
    .rd_en   (book_rd_en),
    .rd_addr (sel),
    .rd_data (book_rd)
  );

  // a room never written since reset reads as free at zero with no bookings
  assign free_rd_m      = free_vld_q ? free_rd : '0;
  assign scan_ctl.step  = rd_pend;
  assign scan_ctl.first = (rd_addr_q == '0);

  lira_scan #(
    .IDX_W     (IDX_W),
    .TIME_BITS (TIME_BITS)
  ) u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .rd_idx    (rd_addr_q),
    .rd_free   (free_rd_m),
    .start_q   (start_q),
    .found     (found),
    .pick      (pick),
    .early     (early),
    .early_val (early_val)
  );

  always_comb begin
    sel     = found ? pick : early;
    a_start = found ? TIME_BITS'(start_q) : early_val;
    dur     = (end_q > start_q) ? (end_q - start_q) : '0;
    a_sum   = {1'b0, a_start} + (TIME_BITS + 1)'(dur);
    ovf     = a_sum[TIME_BITS];
    a_end   = ovf ? '1 : a_sum[TIME_BITS-1:0];
    bk      = book_vld_q ? book_rd : '0;
    cnt_new = (bk == COUNT_MAX) ? bk : (bk + COUNT_W'(1));
    better  = (cnt_new > best_count) || ((cnt_new == best_count) && (sel < best_room));
    best_room_next = better ? sel : best_room;
  end

  assign sel_ext     = {{ROOM_W{1'b0}}, sel};
  assign best_ext    = {{ROOM_W{1'b0}}, best_room_next};
  assign a_start_ext = {{OUT_TIME_W{1'b0}}, a_start};
  assign a_end_ext   = {{OUT_TIME_W{1'b0}}, a_end};

  always_ff @(posedge clk) begin
    if (fire) begin
      room         <= sel_ext[ROOM_W-1:0];
      actual_start <= a_start_ext[OUT_TIME_W-1:0];
      actual_end   <= a_end_ext[OUT_TIME_W-1:0];
      delayed      <= ~found;
      overflow     <= ovf;
      busiest_room <= best_ext[ROOM_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/lira_chk.sv -----
// port-level checker for the room allocator, bound to the top level
// depends on lira_pkg and lowest_index_room_allocator_assert.svh
`default_nettype none

`include "lowest_index_room_allocator_assert.svh"

module lira_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lira_pkg::ROOM_W-1:0]     room,
  input logic [lira_pkg::OUT_TIME_W-1:0] actual_start,
  input logic [lira_pkg::OUT_TIME_W-1:0] actual_end,
  input logic                            delayed,
  input logic                            overflow,
  input logic [lira_pkg::ROOM_W-1:0]     busiest_room
);

  import lira_pkg::*;

  // one item at a time: taking an item closes the input
  `LIRA_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "item taken while busy")

  // a stalled result holds
  `LIRA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(room) && $stable(actual_start) && $stable(actual_end) && $stable(delayed) && $stable(overflow) && $stable(busiest_room), "stalled result changed")

  // an item run as asked starts at its own 32-bit start
  `LIRA_ASSERT_IMP(a_ontime_start, out_valid && !delayed, actual_start[OUT_TIME_W-1:IN_W] == '0, "on-time start out of range")

  // an on-time item never finishes before it starts
  `LIRA_ASSERT_IMP(a_end_order, out_valid && !delayed && !overflow, actual_end >= actual_start, "finish before start")

  `LIRA_ASSERT_RST(a_reset_empty, rst, !out_valid, "result present after reset")

endmodule

bind lowest_index_room_allocator lira_chk u_lira_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .room         (room),
  .actual_start (actual_start),
  .actual_end   (actual_end),
  .delayed      (delayed),
  .overflow     (overflow),
  .busiest_room (busiest_room)
);

`default_nettype wire

// ----- tb/lowest_index_room_allocator_checker.sv -----
`timescale 1ns / 100ps
// booking predictor and result checker for the lowest-index room allocator
// watches the cfg, in and out channels beside the block; depends on lira_pkg

module lowest_index_room_allocator_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lira_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [lira_pkg::IN_W-1:0]       start_time,
  input  logic [lira_pkg::IN_W-1:0]       stop_time,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [lira_pkg::ROOM_W-1:0]     room,
  input  logic [lira_pkg::OUT_TIME_W-1:0] actual_start,
  input  logic [lira_pkg::OUT_TIME_W-1:0] actual_end,
  input  logic                            delayed,
  input  logic                            overflow,
  input  logic [lira_pkg::ROOM_W-1:0]     busiest_room,
  output int                              fail_count,
  output int                              pending,
  output int                              delayed_count,
  output int                              overflow_count
);

  localparam int ROOMS   = 16;
  localparam int ROOM_W  = lira_pkg::ROOM_W;
  localparam int TIME_W  = lira_pkg::OUT_TIME_W;
  localparam int IN_W    = lira_pkg::IN_W;
  localparam int COUNT_W = lira_pkg::COUNT_W;

  typedef struct packed {
    logic [ROOM_W-1:0] room;
    logic [TIME_W-1:0] begins;
    logic [TIME_W-1:0] finishes;
    logic              late;
    logic              saturated;
    logic [ROOM_W-1:0] busiest;
  } booking_t;

  logic [TIME_W-1:0]         free_at [ROOMS];
  logic [COUNT_W-1:0]        bookings [ROOMS];
  logic [ROOM_W-1:0]         top_room;
  logic [COUNT_W-1:0]        top_count;
  logic [lira_pkg::CFG_W-1:0] rooms_setting;
  booking_t                  expected_bookings [$];
  int                        results_seen = 0;

  // places one request and updates the room state
  function automatic booking_t allocate_room(input logic [IN_W-1:0] s,
                                             input logic [IN_W-1:0] e);
    booking_t         b;
    int               n;
    int               pick;
    int               early;
    int               i;
    bit               found;
    logic [IN_W-1:0]  span;
    logic [TIME_W:0]  finish;
    if (rooms_setting == 0) n = 1;
    else if (int'(rooms_setting) > ROOMS) n = ROOMS;
    else n = int'(rooms_setting);
    span  = (e > s) ? e - s : '0;
    pick  = 0;
    early = 0;
    found = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!found && free_at[i] <= TIME_W'(s)) begin
        pick  = i;
        found = 1'b1;
      end
      if (free_at[i] < free_at[early]) early = i;
    end
    if (!found) pick = early;
    b.room      = ROOM_W'(pick);
    b.late      = !found;
    b.begins    = found ? TIME_W'(s) : free_at[early];
    finish      = {1'b0, b.begins} + (TIME_W + 1)'(span);
    b.saturated = finish[TIME_W];
    b.finishes  = finish[TIME_W] ? '1 : finish[TIME_W-1:0];
    free_at[pick] = b.finishes;
    if (bookings[pick] != lira_pkg::COUNT_MAX) bookings[pick] = bookings[pick] + COUNT_W'(1);
    if (bookings[pick] > top_count ||
        (bookings[pick] == top_count && ROOM_W'(pick) < top_room)) begin
      top_count = bookings[pick];
      top_room  = ROOM_W'(pick);
    end
    b.busiest = top_room;
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    fail_count++;
    $display("%t result %0d: %s got %0h, expected %0h", $time, results_seen, what,
             got, want);
  endtask

  task automatic check_booking();
    booking_t want;
    if (expected_bookings.size() == 0) begin
      report_mismatch("result with no request outstanding, room", TIME_W'(room), '0);
      return;
    end
    want = expected_bookings.pop_front();
    if (room !== want.room) report_mismatch("room", TIME_W'(room), TIME_W'(want.room));
    if (actual_start !== want.begins) report_mismatch("actual_start", actual_start, want.begins);
    if (actual_end !== want.finishes) report_mismatch("actual_end", actual_end, want.finishes);
    if (delayed !== want.late) report_mismatch("delayed", TIME_W'(delayed), TIME_W'(want.late));
    if (overflow !== want.saturated)
      report_mismatch("overflow", TIME_W'(overflow), TIME_W'(want.saturated));
    if (busiest_room !== want.busiest)
      report_mismatch("busiest_room", TIME_W'(busiest_room), TIME_W'(want.busiest));
    if (want.late) delayed_count++;
    if (want.saturated) overflow_count++;
    results_seen++;
  endtask

  // a result is checked before the same edge's request is predicted
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROOMS; i++) begin
        free_at[i]  = '0;
        bookings[i] = '0;
      end
      top_room      = '0;
      top_count     = '0;
      rooms_setting = lira_pkg::CFG_RESET;
      expected_bookings.delete();
    end else begin
      if (cfg_valid && cfg_ready) rooms_setting = cfg_data;
      if (out_valid && out_ready) check_booking();
      if (in_valid && in_ready)
        expected_bookings.insert(expected_bookings.size(),
                                 allocate_room(start_time, stop_time));
    end
    pending <= expected_bookings.size();
  end

endmodule

// ----- tb/lowest_index_room_allocator_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the lowest-index room allocator: clock, reset, requests and verdict
// depends on lira_pkg, the allocator rtl and lowest_index_room_allocator_checker

module lowest_index_room_allocator_tb;

  localparam int          HOLD_CYCLES    = 400;
  localparam int          TAIL_ITEMS     = 20;
  localparam logic [31:0] TIME_TOP       = '1;

  logic                            clk        = 1'b0;
  logic                            rst        = 1'b1;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [lira_pkg::CFG_W-1:0]      cfg_data   = '0;
  logic                            in_valid   = 1'b0;
  logic                            in_ready;
  logic [lira_pkg::IN_W-1:0]       start_time = '0;
  logic [lira_pkg::IN_W-1:0]       stop_time  = '0;
  logic                            out_valid;
  logic                            out_ready  = 1'b0;
  logic [lira_pkg::ROOM_W-1:0]     room;
  logic [lira_pkg::OUT_TIME_W-1:0] actual_start;
  logic [lira_pkg::OUT_TIME_W-1:0] actual_end;
  logic                            delayed;
  logic                            overflow;
  logic [lira_pkg::ROOM_W-1:0]     busiest_room;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int requests_sent = 0;
  int room_settings = 0;
  int fail_count;
  int pending;
  int delayed_count;
  int overflow_count;
  logic [31:0] now = '0;
  logic [lira_pkg::CFG_W-1:0] room_plan [12] =
    '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd2, 5'd8, 5'd17, 5'd4, 5'd16, 5'd5, 5'd1};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lowest_index_room_allocator uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_time   (start_time),
    .stop_time    (stop_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .room         (room),
    .actual_start (actual_start),
    .actual_end   (actual_end),
    .delayed      (delayed),
    .overflow     (overflow),
    .busiest_room (busiest_room)
  );

  lowest_index_room_allocator_checker booking_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_time     (start_time),
    .stop_time      (stop_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .room           (room),
    .actual_start   (actual_start),
    .actual_end     (actual_end),
    .delayed        (delayed),
    .overflow       (overflow),
    .busiest_room   (busiest_room),
    .fail_count     (fail_count),
    .pending        (pending),
    .delayed_count  (delayed_count),
    .overflow_count (overflow_count)
  );

  // receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input logic [31:0] s, input logic [31:0] e);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    start_time <= s;
    stop_time  <= e;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_rooms(input logic [lira_pkg::CFG_W-1:0] n);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    room_settings++;
  endtask

  // mostly runs of ascending starts with short bookings, some unordered noise
  task automatic run_segment(input int count);
    int left;
    int burst;
    int step_max;
    int step;
    logic [31:0] s;
    logic [31:0] e;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99) < 20) begin
        s = $urandom;
        case ($urandom_range(3))
          0: e = $urandom;
          1: e = s;
          2: e = TIME_TOP;
          default: e = s - $urandom_range(1, 1000);
        endcase
        send_request(s, e);
        left--;
      end else begin
        burst    = $urandom_range(6, 30);
        step_max = $urandom_range(1) ? 3 : 40;
        case ($urandom_range(3))
          0: now = $urandom_range(0, 100);
          1: now = TIME_TOP - $urandom_range(0, 2000);
          2: now = $urandom;
          default: now = now;
        endcase
        while (burst > 0 && left > 0) begin
          s = now;
          case ($urandom_range(9))
            0: e = s;
            1: e = s + $urandom;
            default: e = s + $urandom_range(1, 80);
          endcase
          send_request(s, e);
          left--;
          burst--;
          step = $urandom_range(0, step_max);
          if (TIME_TOP - now >= step) now = now + step;
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // two rooms: free pick, postponement, zero and negative spans, time extremes
    set_rooms(5'd2);
    send_request(32'd0, 32'd10);
    send_request(32'd0, 32'd5);
    send_request(32'd0, TIME_TOP);
    send_request(32'd5, 32'd5);
    send_request(32'd20, 32'd10);
    send_request(TIME_TOP, TIME_TOP);
    send_request(32'd3, 32'd4);
    // zero rooms behaves as one
    set_rooms(5'd0);
    send_request(32'd1, 32'd2);
    // oversized settings clamp to sixteen, older counts still compete
    set_rooms(5'd31);
    send_request(32'd0, 32'd1);
    send_request(TIME_TOP, 32'd0);
    set_rooms(5'd17);
    send_request(32'd0, TIME_TOP);
    send_request(32'd0, TIME_TOP);
    send_request(32'd0, TIME_TOP);
    set_rooms(5'd1);
    send_request(32'haaaa_aaaa, 32'h5555_5555);
    send_request(32'h5555_5555, 32'haaaa_aaaa);
    set_rooms(5'd16);
    send_request(32'd0, 32'd0);

    room_plan[6]  = 5'($urandom_range(0, 31));
    room_plan[10] = 5'($urandom_range(0, 31));
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 13 : (p == 1) ? 66 : 0;
      recv_idle_pct = (p == 0) ? 66 : (p == 1) ? 13 : 0;
      for (int g = 0; g < 4; g++) begin
        set_rooms(room_plan[p * 4 + g]);
        if (g == 0) hold_reqs++;
        run_segment(63);
        wait_idle();
        run_segment(63);
      end
    end

    // one room, longest spans back to back
    set_rooms(5'd1);
    for (int k = 0; k < TAIL_ITEMS; k++) send_request(32'd0, TIME_TOP);
    send_request(32'd0, 32'd0);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("covered %0d requests under %0d room settings, with long output hold-offs",
             requests_sent, room_settings);
    $display("%0d postponed bookings and %0d saturated finish times among them",
             delayed_count, overflow_count);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
